>>> rtl/tpp_pkg.sv
package tpp_pkg;

  localparam logic [11:0] ID_MASK = 12'hFFF;
  localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;
  localparam logic [31:0] SUM_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] SUM_MIN = 32'h8000_0000;

  typedef enum logic {
    CMD_RECORD = 1'b0,
    CMD_READ   = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t               cmd;
    logic [11:0]        trans_id;
    logic signed [15:0] event_time;
    logic [5:0]         read_row;
    logic [5:0]         read_col;
  } item_t;

  typedef struct packed {
    logic [5:0]         local_index;
    logic               new_entry;
    logic               table_full;
    logic [31:0]        pair_count;
    logic signed [31:0] delay_sum;
    logic [11:0]        row_id;
    logic [6:0]         entries_used;
  } result_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MATCH,
    ST_ENCODE,
    ST_MEMRD,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic match;
    logic encode;
    logic memrd;
    logic update;
  } ctrl_t;

  typedef struct packed {
    logic clear_last;
  } status_t;

endpackage

>>> rtl/tpp_ctrl.sv
module tpp_ctrl
  import tpp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  status_t status,
  output ctrl_t   ctrl,
  output logic    busy
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:  state_next = status.clear_last ? ST_IDLE : ST_CLEAR;
      ST_IDLE:   state_next = start ? ST_MATCH : ST_IDLE;
      ST_MATCH:  state_next = ST_ENCODE;
      ST_ENCODE: state_next = ST_MEMRD;
      ST_MEMRD:  state_next = ST_UPDATE;
      ST_UPDATE: state_next = start ? ST_MATCH : ST_IDLE;
      default:   state_next = ST_CLEAR;
    endcase
  end

  // Take a new item in the final step of the current one.
  always_comb begin
    ctrl        = '0;
    busy        = 1'b1;
    unique case (state)
      ST_CLEAR:  ctrl.clear = 1'b1;
      ST_IDLE: begin
        busy      = 1'b0;
        ctrl.load = start;
      end
      ST_MATCH:  ctrl.match  = 1'b1;
      ST_ENCODE: ctrl.encode = 1'b1;
      ST_MEMRD:  ctrl.memrd  = 1'b1;
      ST_UPDATE: begin
        busy        = 1'b0;
        ctrl.update = 1'b1;
        ctrl.load   = start;
      end
      default: busy = 1'b1;
    endcase
  end

endmodule

>>> rtl/tpp_dpath.sv
module tpp_dpath
  import tpp_pkg::*;
#(
  parameter int TABLE_DEPTH = 64
) (
  input  logic    clk,
  input  logic    rst,
  input  ctrl_t   ctrl,
  input  item_t   item,
  output status_t status,
  output logic    done,
  output result_t result
);

  localparam int IW    = $clog2(TABLE_DEPTH);
  localparam int CW    = $clog2(TABLE_DEPTH + 1);
  localparam int AW    = 2 * IW;
  localparam int CELLS = 1 << AW;

  // latched item
  cmd_t        cmd_q;
  logic [11:0] id_q;
  logic [15:0] t_q;
  logic [5:0]  row_q;
  logic [5:0]  col_q;

  // tag store: flops for the parallel compare, RAM copy for row reads
  logic [11:0] tags [TABLE_DEPTH];
  logic [11:0] tag_ram [TABLE_DEPTH];
  logic [11:0] tag_rd;
  logic [CW-1:0] count;

  logic [TABLE_DEPTH-1:0] match;
  logic [IW-1:0] enc;
  logic          hit;

  logic [IW-1:0] lidx, lidx_c;
  logic          isnew, full, found;
  logic          cell_ok, row_ok;
  logic [AW-1:0] addr;

  logic [IW-1:0] prev_index;
  logic [15:0]   prev_time;
  logic          have_prev;

  logic [31:0] cnt_mem [CELLS];
  logic [31:0] dly_mem [CELLS];
  logic [31:0] rd_cnt, rd_dly;
  logic [AW-1:0] clr_addr;

  logic [IW+5:0] row_ext, col_ext, lidx_ext;
  logic [CW+6:0] count_ext;
  logic [IW-1:0] row_i, col_i;
  logic          row_in, col_in, row_used, insert;

  logic [16:0] diff;
  logic [32:0] dsum_w;
  logic [31:0] dly_new, cnt_new;
  logic        do_write;

  assign row_ext   = {{IW{1'b0}}, row_q};
  assign col_ext   = {{IW{1'b0}}, col_q};
  assign row_i     = row_ext[IW-1:0];
  assign col_i     = col_ext[IW-1:0];
  assign lidx_ext  = {6'b0, lidx};
  assign count_ext = {7'b0, count};

  assign row_in   = {26'b0, row_q} < 32'(TABLE_DEPTH);
  assign col_in   = {26'b0, col_q} < 32'(TABLE_DEPTH);
  assign row_used = {26'b0, row_q} < 32'(count);

  assign status.clear_last = &clr_addr;

  always_comb begin
    hit = |match;
    enc = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (match[i]) enc = enc | IW'(i);
    end
  end

  assign insert = !hit && (32'(count) < 32'(TABLE_DEPTH));
  assign lidx_c = hit ? enc : (insert ? count[IW-1:0] : '0);

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_q <= item.cmd;
      id_q  <= item.trans_id & ID_MASK;
      t_q   <= item.event_time;
      row_q <= item.read_row;
      col_q <= item.read_col;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.match) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        match[i] <= (tags[i] == id_q) && (int'(count) > i);
      end
    end
  end

  // Resolve the index: hit, insert at the fill point, or drop when full.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctrl.encode && cmd_q == CMD_RECORD && insert) begin
      count <= count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.encode) begin
      if (cmd_q == CMD_RECORD) begin
        lidx    <= lidx_c;
        isnew   <= insert;
        full    <= !hit && !insert;
        found   <= hit || insert;
        addr    <= {prev_index, lidx_c};
        cell_ok <= 1'b0;
        row_ok  <= 1'b0;
        if (insert) begin
          tags[count[IW-1:0]]    <= id_q;
          tag_ram[count[IW-1:0]] <= id_q;
        end
      end else begin
        lidx    <= '0;
        isnew   <= 1'b0;
        full    <= 1'b0;
        found   <= 1'b0;
        addr    <= {row_i, col_i};
        cell_ok <= row_in && col_in;
        row_ok  <= row_in && row_used;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.memrd) begin
      tag_rd <= tag_ram[row_i];
      rd_cnt <= cnt_mem[addr];
      rd_dly <= dly_mem[addr];
    end
  end

  assign diff   = {t_q[15], t_q} - {prev_time[15], prev_time};
  assign dsum_w = {rd_dly[31], rd_dly} + {{16{diff[16]}}, diff};
  always_comb begin
    if (dsum_w[32] != dsum_w[31]) begin
      dly_new = dsum_w[32] ? SUM_MIN : SUM_MAX;
    end else begin
      dly_new = dsum_w[31:0];
    end
  end
  assign cnt_new  = (rd_cnt == CNT_MAX) ? rd_cnt : rd_cnt + 32'd1;
  assign do_write = ctrl.update && cmd_q == CMD_RECORD && found && have_prev;

  // Single write port shared by the clearing sweep and the cell update.
  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      cnt_mem[clr_addr] <= '0;
      dly_mem[clr_addr] <= '0;
    end else if (do_write) begin
      cnt_mem[addr] <= cnt_new;
      dly_mem[addr] <= dly_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (ctrl.clear) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_index <= '0;
      prev_time  <= '0;
      have_prev  <= 1'b0;
    end else if (ctrl.update && cmd_q == CMD_RECORD && found) begin
      prev_index <= lidx;
      prev_time  <= t_q;
      have_prev  <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctrl.update;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.update) begin
      result.local_index  <= lidx_ext[5:0];
      result.new_entry    <= isnew;
      result.table_full   <= full;
      result.pair_count   <= cell_ok ? rd_cnt : '0;
      result.delay_sum    <= cell_ok ? rd_dly : '0;
      result.row_id       <= row_ok ? tag_rd : '0;
      result.entries_used <= count_ext[6:0];
    end
  end

endmodule

>>> rtl/transition_pair_profiler_unit.sv
// Transition pair profiler. Each record item maps its 12-bit transition id
// to a dense local index through a lookup-or-insert tag table and, from the
// second mapped event on, bumps the [previous][current] cell of a count
// matrix and adds the timestamp difference to the same cell of a delay-sum
// matrix (both saturating). A read item returns one cell, the id stored at
// the row and the fill level. Exactly one result follows every item, shown
// for one cycle with done high; the receiver cannot stall, so sample it
// then. A new item can be accepted before the previous one is through:
// start is taken in the cycle the previous result is being finished, and
// the result is registered after the tag compare, the index encode and the
// read-modify-write of the single-port matrix memories. After reset busy
// stays high for a clearing sweep over every cell of the matrices. When the
// table is full an unknown id is dropped and flagged by table_full.
module transition_pair_profiler_unit
  import tpp_pkg::*;
#(
  parameter int TABLE_DEPTH = 64
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  item_t   item,
  output logic    done,
  output result_t result
);

  ctrl_t   ctrl;
  status_t status;

  // sequencing
  tpp_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .ctrl   (ctrl),
    .busy   (busy)
  );

  // tag table, matrices, previous-event state and result register
  tpp_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dpath (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .item   (item),
    .status (status),
    .done   (done),
    .result (result)
  );

  // A result strobe comes only from the update step.
  a_done_from_update: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(ctrl.update))
    else $error("result strobe without an update step");

  // An accepted item always occupies the block in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("block idle right after accepting an item");

  // Insert and drop exclude each other.
  a_new_or_full: assert property (@(posedge clk) disable iff (rst)
    done |-> !(result.new_entry && result.table_full))
    else $error("item both inserted and dropped");

  // A drop happens only with the table filled to capacity.
  a_full_level: assert property (@(posedge clk) disable iff (rst)
    (done && result.table_full) |-> (result.entries_used == 7'(TABLE_DEPTH)))
    else $error("drop reported below capacity");

endmodule
